/* src/slpf_pkg.sv */
package slpf_pkg;

   localparam int SLPF_COORD_WIDTH = 32;

   // handoff between the front queue and the back sequencer
   typedef struct packed {
      logic valid;
      logic anchor;
   } slpf_qctl_type;

endpackage

/* src/slpf_if.sv */
interface slpf_req_if #(parameter int CW = 32) ();
   logic valid;
   logic ready;
   logic start_strand;
   logic signed [CW-1:0] old_x;
   logic signed [CW-1:0] old_y;
   logic signed [CW-1:0] old_z;
   logic signed [CW-1:0] new_x;
   logic signed [CW-1:0] new_y;
   logic signed [CW-1:0] new_z;
   modport source (output valid, start_strand, old_x, old_y, old_z, new_x, new_y, new_z,
                   input ready);
   modport sink (input valid, start_strand, old_x, old_y, old_z, new_x, new_y, new_z,
                 output ready);
endinterface

interface slpf_rsp_if #(parameter int CW = 32) ();
   logic valid;
   logic ready;
   logic signed [CW-1:0] rev_x;
   logic signed [CW-1:0] rev_y;
   logic signed [CW-1:0] rev_z;
   logic zero_length;
   modport source (output valid, rev_x, rev_y, rev_z, zero_length, input ready);
   modport sink (input valid, rev_x, rev_y, rev_z, zero_length, output ready);
endinterface

/* src/slpf_front.sv */
module slpf_front import slpf_pkg::*; #(
   parameter int COORD_WIDTH = SLPF_COORD_WIDTH
) (
   input  logic clock,
   input  logic reset,
   slpf_req_if.sink req_chan,
   output slpf_qctl_type q_ctl,
   output logic [2:0][COORD_WIDTH-1:0] q_old,
   output logic [2:0][COORD_WIDTH-1:0] q_new,
   input  logic q_pop
);
   localparam int CW = COORD_WIDTH;

   logic [1:0][2:0][CW-1:0] old_ff, new_ff;
   logic [1:0] anchor_ff;
   logic wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic push, pop;

   assign req_chan.ready = (count_ff != 2'd2);
   assign push = req_chan.valid && req_chan.ready;
   assign pop = q_pop && (count_ff != 2'd0);

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   // classification: anchors bypass all length math in the back end
   assign q_ctl.valid = (count_ff != 2'd0);
   assign q_ctl.anchor = anchor_ff[rd_ptr_ff];
   assign q_old = old_ff[rd_ptr_ff];
   assign q_new = new_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         anchor_ff[wr_ptr_ff] <= req_chan.start_strand;
         old_ff[wr_ptr_ff] <= {req_chan.old_z, req_chan.old_y, req_chan.old_x};
         new_ff[wr_ptr_ff] <= {req_chan.new_z, req_chan.new_y, req_chan.new_x};
      end
   end
endmodule

/* src/slpf_back.sv */
module slpf_back import slpf_pkg::*; #(
   parameter int COORD_WIDTH = SLPF_COORD_WIDTH
) (
   input  logic clock,
   input  logic reset,
   input  slpf_qctl_type q_ctl,
   input  logic [2:0][COORD_WIDTH-1:0] q_old,
   input  logic [2:0][COORD_WIDTH-1:0] q_new,
   output logic q_pop,
   slpf_rsp_if.source rsp_chan
);
   localparam int CW = COORD_WIDTH;
   localparam int MW = CW + 1;
   localparam int SQW = CW + 2;
   localparam int PRW = 2 * CW + 4;
   localparam int EW = CW + 4;
   localparam int CNTW = $clog2(PRW);
   localparam logic signed [EW-1:0] MAXV = {{(EW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [EW-1:0] MINV = {{(EW-CW+1){1'b1}}, {(CW-1){1'b0}}};
   localparam logic [SQW-1:0] QCAP = {2'b10, {(CW){1'b0}}};

   typedef enum logic [7:0] {
      S_IDLE = 8'b00000001,
      S_LOAD = 8'b00000010,
      S_MSET = 8'b00000100,
      S_MUL  = 8'b00001000,
      S_ROOT = 8'b00010000,
      S_DIV  = 8'b00100000,
      S_FIN  = 8'b01000000,
      S_OUT  = 8'b10000000
   } state_type;

   function automatic logic [CW-1:0] sat(input logic signed [EW-1:0] v);
      if (v > MAXV) return MAXV[CW-1:0];
      if (v < MINV) return MINV[CW-1:0];
      return v[CW-1:0];
   endfunction

   function automatic logic signed [EW-1:0] sx(input logic [CW-1:0] a);
      return {{(EW-CW){a[CW-1]}}, a};
   endfunction

   function automatic logic [MW-1:0] amag(input logic [CW-1:0] a, input logic [CW-1:0] b);
      logic signed [EW-1:0] d;
      d = sx(a) - sx(b);
      if (d < 0) d = -d;
      return d[MW-1:0];
   endfunction

   state_type state_ff, state_in;
   logic [3:0] k_ff, k_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic anchor_ff, anchor_in;
   logic [2:0][CW-1:0] new_ff, new_in, old_ff, old_in, xb_ff, xb_in, res_ff, res_in;
   logic [2:0][CW-1:0] pold_ff, pold_in, prev_ff, prev_in, acc_ff, acc_in;
   logic [5:0][MW-1:0] mag_ff, mag_in;
   logic [PRW-1:0] prod_ff, prod_in, mcand_ff, mcand_in, rad_ff, rad_in;
   logic [SQW-1:0] mplier_ff, mplier_in, root_ff, root_in, lp_ff, lp_in, ln_ff, ln_in;
   logic [SQW+1:0] rem_ff, rem_in;
   logic flag_ff, flag_in;
   logic out_v_ff, out_v_in;
   logic [2:0][CW-1:0] out_ff, out_in;
   logic out_flag_ff, out_flag_in;

   always_comb begin
      logic [SQW+3:0] rem2, trial;
      logic [SQW:0] t;
      logic [SQW-1:0] qc;
      logic [1:0] c;
      logic signed [EW-1:0] sq, rv;
      logic [CW-1:0] xbv;
      rem2 = '0;
      trial = '0;
      t = '0;
      qc = '0;
      sq = '0;
      rv = '0;
      xbv = '0;
      state_in = state_ff;
      k_in = k_ff;
      cnt_in = cnt_ff;
      anchor_in = anchor_ff;
      new_in = new_ff;
      old_in = old_ff;
      xb_in = xb_ff;
      res_in = res_ff;
      pold_in = pold_ff;
      prev_in = prev_ff;
      acc_in = acc_ff;
      mag_in = mag_ff;
      prod_in = prod_ff;
      mcand_in = mcand_ff;
      rad_in = rad_ff;
      mplier_in = mplier_ff;
      root_in = root_ff;
      lp_in = lp_ff;
      ln_in = ln_ff;
      rem_in = rem_ff;
      flag_in = flag_ff;
      out_v_in = out_v_ff;
      out_in = out_ff;
      out_flag_in = out_flag_ff;
      q_pop = 1'b0;
      c = 2'(k_ff - 4'd6);
      if (out_v_ff && rsp_chan.ready) out_v_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (q_ctl.valid) begin
               q_pop = 1'b1;
               anchor_in = q_ctl.anchor;
               old_in = q_old;
               new_in = q_new;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            pold_in = old_ff;
            flag_in = 1'b0;
            k_in = 4'd0;
            if (anchor_ff) begin
               res_in = new_ff;
               prev_in = new_ff;
               acc_in = '0;
               state_in = S_OUT;
            end else begin
               for (int i = 0; i < 3; i++) begin
                  xbv = sat(sx(new_ff[i]) + sx(acc_ff[i]));
                  xb_in[i] = xbv;
                  mag_in[i] = amag(old_ff[i], pold_ff[i]);
                  mag_in[i+3] = amag(xbv, prev_ff[i]);
               end
               state_in = S_MSET;
            end
         end
         S_MSET: begin
            cnt_in = '0;
            if (k_ff < 4'd6) begin
               mcand_in = PRW'(mag_ff[3'(k_ff)]);
               mplier_in = SQW'(mag_ff[3'(k_ff)]);
            end else begin
               mcand_in = PRW'(mag_ff[3'(k_ff - 4'd3)]);
               mplier_in = lp_ff;
            end
            if (k_ff == 4'd0 || k_ff == 4'd3 || k_ff >= 4'd6) prod_in = '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            // shift-add, one multiplier bit per cycle
            if (mplier_ff[0]) prod_in = prod_ff + mcand_ff;
            mcand_in = {mcand_ff[PRW-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[SQW-1:1]};
            cnt_in = cnt_ff + CNTW'(1);
            if (cnt_ff == CNTW'(SQW - 1)) begin
               cnt_in = '0;
               if (k_ff == 4'd2 || k_ff == 4'd5) begin
                  rad_in = mplier_ff[0] ? prod_ff + mcand_ff : prod_ff;
                  rem_in = '0;
                  root_in = '0;
                  state_in = S_ROOT;
               end else if (k_ff < 4'd6) begin
                  k_in = k_ff + 4'd1;
                  state_in = S_MSET;
               end else begin
                  rem_in = '0;
                  state_in = S_DIV;
               end
            end
         end
         S_ROOT: begin
            // digit-by-digit square root, one root bit per cycle
            rem2 = {rem_ff, rad_ff[PRW-1:PRW-2]};
            trial = (SQW+4)'({root_ff, 2'b01});
            rad_in = {rad_ff[PRW-3:0], 2'b00};
            if (rem2 >= trial) begin
               rem_in = (SQW+2)'(rem2 - trial);
               root_in = {root_ff[SQW-2:0], 1'b1};
            end else begin
               rem_in = rem2[SQW+1:0];
               root_in = {root_ff[SQW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CNTW'(1);
            if (cnt_ff == CNTW'(SQW - 1)) begin
               cnt_in = '0;
               if (k_ff == 4'd2) begin
                  lp_in = root_in;
                  k_in = 4'd3;
                  state_in = S_MSET;
               end else begin
                  ln_in = root_in;
                  if (root_in == '0) begin
                     flag_in = 1'b1;
                     res_in = xb_ff;
                     prev_in = xb_ff;
                     state_in = S_OUT;
                  end else begin
                     k_in = 4'd6;
                     state_in = S_MSET;
                  end
               end
            end
         end
         S_DIV: begin
            // restoring division, quotient bits shift into the product register
            t = {rem_ff[SQW-1:0], prod_ff[PRW-1]};
            if (t >= {1'b0, ln_ff}) begin
               rem_in = (SQW+2)'(t - {1'b0, ln_ff});
               prod_in = {prod_ff[PRW-2:0], 1'b1};
            end else begin
               rem_in = (SQW+2)'(t);
               prod_in = {prod_ff[PRW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CNTW'(1);
            if (cnt_ff == CNTW'(PRW - 1)) begin
               cnt_in = '0;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (|prod_ff[PRW-1:CW+1]) qc = QCAP;
            else qc = SQW'(prod_ff[CW:0]) +
                      SQW'({rem_ff[SQW-1:0], 1'b0} >= {1'b0, ln_ff});
            sq = EW'(qc);
            if (sx(xb_ff[c]) < sx(prev_ff[c])) sq = -sq;
            rv = sx(prev_ff[c]) + sq;
            res_in[c] = sat(rv);
            acc_in[c] = sat(sx(acc_ff[c]) + sx(sat(rv)) - sx(xb_ff[c]));
            prev_in[c] = sat(rv);
            if (k_ff == 4'd8) begin
               state_in = S_OUT;
            end else begin
               k_in = k_ff + 4'd1;
               state_in = S_MSET;
            end
         end
         S_OUT: begin
            if (!out_v_ff || rsp_chan.ready) begin
               out_v_in = 1'b1;
               out_in = res_ff;
               out_flag_in = flag_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_chan.valid = out_v_ff;
   assign rsp_chan.rev_x = out_ff[0];
   assign rsp_chan.rev_y = out_ff[1];
   assign rsp_chan.rev_z = out_ff[2];
   assign rsp_chan.zero_length = out_flag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_v_ff <= 1'b0;
         k_ff <= 4'd0;
         cnt_ff <= '0;
         pold_ff <= '0;
         prev_ff <= '0;
         acc_ff <= '0;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
         k_ff <= k_in;
         cnt_ff <= cnt_in;
         pold_ff <= pold_in;
         prev_ff <= prev_in;
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      anchor_ff <= anchor_in;
      new_ff <= new_in;
      old_ff <= old_in;
      xb_ff <= xb_in;
      res_ff <= res_in;
      mag_ff <= mag_in;
      prod_ff <= prod_in;
      mcand_ff <= mcand_in;
      rad_ff <= rad_in;
      mplier_ff <= mplier_in;
      root_ff <= root_in;
      lp_ff <= lp_in;
      ln_ff <= ln_in;
      rem_ff <= rem_in;
      flag_ff <= flag_in;
      out_ff <= out_in;
      out_flag_ff <= out_flag_in;
   end
endmodule

/* src/strand_length_preserve_filter_top.sv */
// Length-preserving follow-the-leader filter for polyline strands. One vertex per
// transaction: old and tentative new positions, Q(COORD_WIDTH-16).16 by default (the
// binary point does not affect the math). Anchor vertices bypass the length math;
// any other vertex passes through the bit-serial shift-add multiplier (up to nine
// products), the digit-by-digit square root (two roots) and the restoring divider
// (three quotients, skipped for a zero-length new segment) in the back end. The
// back end works on one vertex at a time and takes no new vertex until the last
// result is in the result register. A two-entry queue in front keeps accepting
// while the back end works, and the result register holds a finished transaction
// while the next vertex is computed.
module strand_length_preserve_filter_top import slpf_pkg::*; #(
   parameter int COORD_WIDTH = SLPF_COORD_WIDTH
) (
   input logic clock,
   input logic reset,
   slpf_req_if.sink req_chan,
   slpf_rsp_if.source rsp_chan
);
   // front to back handoff
   slpf_qctl_type q_ctl;
   logic [2:0][COORD_WIDTH-1:0] q_old;
   logic [2:0][COORD_WIDTH-1:0] q_new;
   logic q_pop;

   // input queue and classification
   slpf_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .q_ctl(q_ctl),
      .q_old(q_old),
      .q_new(q_new),
      .q_pop(q_pop)
   );

   // strand state, length math and result register
   slpf_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
      .clock(clock),
      .reset(reset),
      .q_ctl(q_ctl),
      .q_old(q_old),
      .q_new(q_new),
      .q_pop(q_pop),
      .rsp_chan(rsp_chan)
   );
endmodule
